// ===== rtl/pstt_pkg.sv =====
// Package for the priority sorted task table: beat types, state and command codes.
// Used by every module of the block; depends on nothing.
package pstt_pkg;

  localparam int unsigned SlotW = 4;
  localparam int unsigned MaxResults = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_WALK   = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] handle;
    logic [7:0]  priority_req;
    logic [3:0]  slot;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] result_slot;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSLINK,
    S_DELETE,
    S_WALK,
    S_EMIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input beat, reset scan cursor
    logic scan_step;  // advance the scan cursor
    logic head_take;  // cursor := found head
    logic follow;     // cursor := next link of cursor
    logic ins_tail;   // link new slot after cursor (tail)
    logic ins_before; // link new slot before cursor
    logic ins_alone;  // new slot alone in list
    logic del_do;     // unlink captured slot
    logic emit;       // load output register from res fields
    logic set_res;    // set result slot/status/last
    logic [1:0] res_status;
    logic res_cur;    // result slot from cursor (else delete slot, sel or zero)
    logic res_last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    mode_e mode;
    logic  scan_done;   // scan cursor has passed the last slot
    logic  hit;         // scan condition met at cursor
    logic  head_found;  // a head has been recorded
    logic  sel_found;   // a free or matching slot has been recorded
    logic  cur_none;    // cursor is no slot
    logic  cur_ge;      // priority at cursor >= new priority
    logic  cur_tail;    // cursor has no next
    logic  del_ok;      // delete slot is in use
    logic  step_done;   // walk step budget spent
    logic  step_last;   // this walk step is the final one allowed
    logic  out_busy;    // output register still holds a beat
  } stat_t;

endpackage

// ===== rtl/pstt_datapath.sv =====
// Datapath of the priority sorted task table: slot store, links, cursor and output register.
// Depends on pstt_pkg; driven by pstt_ctrl.
module pstt_datapath #(
  parameter int unsigned NumSlots = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pstt_pkg::in_beat_t  in_beat_i,
  input  pstt_pkg::cmd_t      cmd_i,
  output pstt_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pstt_pkg::out_beat_t out_beat_o
);
  import pstt_pkg::*;

  localparam int unsigned IdxW  = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned LinkW = $clog2(NumSlots + 1);
  localparam int unsigned CntW  = $clog2(NumSlots + 1);
  localparam int unsigned WalkMax = (NumSlots < MaxResults) ? NumSlots : MaxResults;
  localparam logic [LinkW-1:0] NoneLink = LinkW'(NumSlots);

  logic [NumSlots-1:0] in_use_q;
  logic [31:0]         hdl_q  [NumSlots];
  logic [7:0]          pri_q  [NumSlots];
  logic [LinkW-1:0]    prev_q [NumSlots];
  logic [LinkW-1:0]    next_q [NumSlots];

  in_beat_t         req_q;
  logic [CntW-1:0]  scan_q, steps_q;
  logic [LinkW-1:0] sel_q, cur_q, head_q;
  logic             sel_found_q, head_found_q;
  out_beat_t        res_q, out_q;
  logic             out_valid_q;

  logic [IdxW-1:0] scan_idx, cur_idx, sel_idx, del_idx;
  logic            scan_hit, scan_head, cur_none;
  logic [LinkW-1:0] cur_prev, cur_next;

  assign scan_idx  = scan_q[IdxW-1:0];
  assign cur_idx   = cur_q[IdxW-1:0];
  assign sel_idx   = sel_q[IdxW-1:0];
  assign del_idx   = IdxW'(req_q.slot);
  assign cur_none  = (cur_q >= NoneLink);
  assign cur_prev  = prev_q[cur_idx];
  assign cur_next  = next_q[cur_idx];
  assign scan_head = in_use_q[scan_idx] && (prev_q[scan_idx] == NoneLink);

  always_comb begin
    case (mode_e'(req_q.mode))
      MODE_ADD:  scan_hit = !in_use_q[scan_idx];
      MODE_FIND: scan_hit = in_use_q[scan_idx] && (hdl_q[scan_idx] == req_q.handle);
      default:   scan_hit = scan_head;
    endcase
  end

  always_comb begin
    stat_o            = '0;
    stat_o.mode       = mode_e'(req_q.mode);
    stat_o.scan_done  = (scan_q >= CntW'(NumSlots));
    stat_o.hit        = !stat_o.scan_done && scan_hit;
    stat_o.head_found = head_found_q;
    stat_o.sel_found  = sel_found_q;
    stat_o.cur_none   = cur_none;
    stat_o.cur_ge     = pri_q[cur_idx] >= req_q.priority_req;
    stat_o.cur_tail   = cur_next >= NoneLink;
    stat_o.del_ok     = (32'(req_q.slot) < NumSlots) && in_use_q[del_idx];
    stat_o.step_done  = (steps_q >= CntW'(NumSlots));
    stat_o.step_last  = (steps_q >= CntW'(WalkMax - 1));
    stat_o.out_busy   = out_valid_q && out_stall_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q     <= '0;
      out_valid_q  <= 1'b0;
      sel_found_q  <= 1'b0;
      head_found_q <= 1'b0;
      scan_q       <= '0;
      steps_q      <= '0;
    end else begin
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
      if (cmd_i.load) begin
        scan_q       <= '0;
        steps_q      <= '0;
        sel_found_q  <= 1'b0;
        head_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (stat_o.hit) sel_found_q <= 1'b1;
        if (!stat_o.scan_done && scan_head) head_found_q <= 1'b1;
      end
      if (cmd_i.follow) steps_q <= steps_q + 1'b1;
      if (cmd_i.ins_tail || cmd_i.ins_before || cmd_i.ins_alone) in_use_q[sel_idx] <= 1'b1;
      if (cmd_i.del_do) in_use_q[del_idx] <= 1'b0;
    end
  end

  // Payload registers and link store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_beat_i;
    if (cmd_i.scan_step && stat_o.hit && !sel_found_q) begin
      sel_q <= LinkW'(scan_q);
      if (mode_e'(req_q.mode) == MODE_ADD) begin
        hdl_q[scan_idx] <= req_q.handle;
        pri_q[scan_idx] <= req_q.priority_req;
      end
    end
    if (cmd_i.scan_step && !stat_o.scan_done && scan_head && !head_found_q)
      head_q <= LinkW'(scan_q);
    if (cmd_i.head_take) cur_q <= head_found_q ? head_q : NoneLink;
    if (cmd_i.follow)    cur_q <= cur_next;
    if (cmd_i.ins_alone) begin
      prev_q[sel_idx] <= NoneLink;
      next_q[sel_idx] <= NoneLink;
    end
    if (cmd_i.ins_tail) begin
      next_q[cur_idx] <= sel_q;
      prev_q[sel_idx] <= cur_q;
      next_q[sel_idx] <= NoneLink;
    end
    if (cmd_i.ins_before) begin
      prev_q[sel_idx] <= cur_prev;
      next_q[sel_idx] <= cur_q;
      if (cur_prev < NoneLink) next_q[cur_prev[IdxW-1:0]] <= sel_q;
      prev_q[cur_idx] <= sel_q;
    end
    if (cmd_i.del_do) begin
      if (prev_q[del_idx] < NoneLink) next_q[prev_q[del_idx][IdxW-1:0]] <= next_q[del_idx];
      if (next_q[del_idx] < NoneLink) prev_q[next_q[del_idx][IdxW-1:0]] <= prev_q[del_idx];
    end
    if (cmd_i.set_res) begin
      res_q.status <= cmd_i.res_status;
      res_q.last   <= cmd_i.res_last;
      if (cmd_i.res_cur) res_q.result_slot <= 4'(cur_q);
      else if (mode_e'(req_q.mode) == MODE_DELETE) res_q.result_slot <= req_q.slot;
      else if (cmd_i.res_status == ST_OK) res_q.result_slot <= 4'(sel_q);
      else res_q.result_slot <= '0;
    end
    if (cmd_i.emit) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== rtl/pstt_ctrl.sv =====
// Controller state machine of the priority sorted task table.
// Depends on pstt_pkg; commands pstt_datapath.
module pstt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pstt_pkg::stat_t stat_i,
  output pstt_pkg::cmd_t  cmd_o
);
  import pstt_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   walk_last;

  // A walk beat is the final one at the tail or when the step budget runs out.
  assign walk_last = stat_i.cur_tail || stat_i.step_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        ret_d = S_IDLE;
        if (stat_i.mode == MODE_DELETE) begin
          state_d = S_DELETE;
        end else if (stat_i.scan_done) begin
          case (stat_i.mode)
            MODE_ADD:  state_d = stat_i.sel_found ? S_INSLINK : S_EMIT;
            MODE_WALK: state_d = stat_i.head_found ? S_WALK : S_EMIT;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      S_INSLINK: begin
        if (stat_i.cur_none || stat_i.cur_ge || stat_i.cur_tail || stat_i.step_done)
          state_d = S_EMIT;
      end
      S_DELETE: state_d = S_EMIT;
      S_WALK: begin
        state_d = S_EMIT;
        ret_d   = walk_last ? S_IDLE : S_WALK;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) state_d = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_SCAN: begin
        if (stat_i.mode != MODE_DELETE) begin
          cmd_o.scan_step = !stat_i.scan_done;
          if (stat_i.scan_done) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_last = 1'b1;
            case (stat_i.mode)
              MODE_ADD: begin
                cmd_o.head_take  = stat_i.sel_found;
                cmd_o.res_status = stat_i.sel_found ? ST_OK : ST_FULL;
              end
              MODE_WALK: begin
                cmd_o.head_take  = 1'b1;
                cmd_o.set_res    = !stat_i.head_found;
                cmd_o.res_status = ST_EMPTY;
              end
              default: cmd_o.res_status = stat_i.sel_found ? ST_OK : ST_NOTFOUND;
            endcase
          end
        end
      end
      S_INSLINK: begin
        if (stat_i.cur_none) cmd_o.ins_alone = 1'b1;
        else if (stat_i.cur_ge || stat_i.step_done) cmd_o.ins_before = 1'b1;
        else if (stat_i.cur_tail) cmd_o.ins_tail = 1'b1;
        else cmd_o.follow = 1'b1;
      end
      S_DELETE: begin
        cmd_o.del_do     = stat_i.del_ok;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_last   = 1'b1;
        cmd_o.res_status = stat_i.del_ok ? ST_OK : ST_NOTFOUND;
      end
      S_WALK: begin
        cmd_o.follow     = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_cur    = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_last   = walk_last;
      end
      S_EMIT: cmd_o.emit = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/priority_sorted_task_table_unit.sv =====
// Top level of the priority sorted task table: joins controller and datapath.
// Depends on pstt_pkg, pstt_ctrl and pstt_datapath.
//
//   channel | direction | beat type  | handshake
//   in      | input     | in_beat_t  | in_valid_i / in_stall_o
//   out     | output    | out_beat_t | out_valid_o / out_stall_i
//
// One item is in work at a time; a beat is taken only in the idle cycle.
// Add, find and walk first scan every slot; delete skips the scan and unlinks
// in its delete state. An add then walks the sorted list one link a cycle to
// the tail or a slot of equal or higher priority and links there. A walk emits
// one beat per entry, walk and emit states in turn. Every result ends in emit.
// Reset clears the in-use bits and the controller; slot contents need none.
// A stalled output holds the controller in its emit state until the beat is taken.
module priority_sorted_task_table_unit #(
  parameter int unsigned NumSlots = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pstt_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pstt_pkg::out_beat_t out_beat_o
);
  import pstt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pstt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .cmd_o(cmd)
  );

  pstt_datapath #(.NumSlots(NumSlots)) u_dp (
    .clk_i, .rst_ni, .in_beat_i, .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_stall_i, .out_beat_o
  );

endmodule

// ===== rtl/pstt_checker.sv =====
// Port checker for the priority sorted task table, bound to the top level.
// Depends on pstt_pkg.
module pstt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pstt_pkg::out_beat_t out_beat_o
);
  import pstt_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status != ST_OK |-> out_beat_o.last)
    else $error("error result not marked last");
endmodule

bind priority_sorted_task_table_unit pstt_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_beat_o
);
